/* hdl/splg_pkg.sv */
// ----------------------------------------------------------------------------
// splg_pkg
// Shared widths, codes and helpers for the styled polyline line generator.
// ----------------------------------------------------------------------------
`default_nettype none

package splg_pkg;

  localparam int COORD_W = 20;
  localparam int DIFF_W  = 21;
  localparam int LEN_W   = 21;
  localparam int MULB_W  = 22;
  localparam int Q_W     = 22;
  localparam int QS_W    = 23;
  localparam int SUM_W   = 26;
  localparam int NUM_W   = 44;
  localparam int SQ_W    = 42;
  localparam int LINE_W  = 4 * COORD_W;

  localparam logic [2:0] STYLE_SOLID    = 3'd0;
  localparam logic [2:0] STYLE_DASHED   = 3'd1;
  localparam logic [2:0] STYLE_ZIGZAG   = 3'd2;
  localparam logic [2:0] STYLE_DOTTED   = 3'd3;
  localparam logic [2:0] STYLE_BACKWARD = 3'd4;

  localparam logic [1:0] PTS_NONE = 2'd0;
  localparam logic [1:0] PTS_ONE  = 2'd1;
  localparam logic [1:0] PTS_MORE = 2'd2;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] a;
    logic [MULB_W-1:0]        b;
    logic [LEN_W-1:0]         d;
  } div_req_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(524287);
    lo = -SUM_W'(524288);
    if (v > hi) begin
      return COORD_W'(hi);
    end else if (v < lo) begin
      return COORD_W'(lo);
    end
    return COORD_W'(v);
  endfunction

endpackage

`default_nettype wire

/* hdl/splg_ram.sv */
// ----------------------------------------------------------------------------
// splg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module splg_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/splg_div.sv */
// ----------------------------------------------------------------------------
// splg_div
// Shared scaling unit: round(a*b/d), half away from zero, one quotient bit
// per cycle after a single multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module splg_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire splg_pkg::div_req_t                req,
  output logic                                   done,
  output logic signed [splg_pkg::QS_W-1:0]       quo
);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_MUL  = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_DONE = 4'b1000
  } div_state_t;

  div_state_t                      state;
  logic [splg_pkg::DIFF_W-1:0]     amag;
  logic                            neg;
  logic [splg_pkg::MULB_W-1:0]     bq;
  logic [splg_pkg::LEN_W-1:0]      dq;
  logic [splg_pkg::NUM_W-1:0]      rem;
  logic [splg_pkg::NUM_W-1:0]      dsh;
  logic [splg_pkg::Q_W-1:0]        q;
  logic [$clog2(splg_pkg::Q_W)-1:0] cnt;
  logic [splg_pkg::DIFF_W+splg_pkg::MULB_W-1:0] prod;

  assign prod = amag * bq;
  assign done = (state == DV_DONE);
  assign quo  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      case (state)
        DV_IDLE: begin
          if (req.start) begin
            amag  <= (req.a < 0) ? splg_pkg::DIFF_W'(-req.a) : splg_pkg::DIFF_W'(req.a);
            neg   <= (req.a < 0);
            bq    <= req.b;
            dq    <= req.d;
            state <= DV_MUL;
          end
        end
        DV_MUL: begin
          rem   <= splg_pkg::NUM_W'(prod) + splg_pkg::NUM_W'(dq >> 1);
          dsh   <= splg_pkg::NUM_W'({dq, {(splg_pkg::Q_W-1){1'b0}}});
          q     <= '0;
          cnt   <= $clog2(splg_pkg::Q_W)'(splg_pkg::Q_W - 1);
          state <= DV_RUN;
        end
        DV_RUN: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[splg_pkg::Q_W-2:0], 1'b1};
          end else begin
            q   <= {q[splg_pkg::Q_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (cnt == '0) begin
            state <= DV_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        DV_DONE: begin
          state <= DV_IDLE;
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/splg_sqrt.sv */
// ----------------------------------------------------------------------------
// splg_sqrt
// Segment length: squared length in the SQX and SQZ states, then a
// digit-by-digit integer square root, two bits of radicand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module splg_sqrt (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [splg_pkg::DIFF_W-1:0] dx,
  input  wire logic signed [splg_pkg::DIFF_W-1:0] dz,
  output logic                                    done,
  output logic [splg_pkg::LEN_W-1:0]              len,
  output logic [splg_pkg::SQ_W-1:0]               len2
);

  typedef enum logic [4:0] {
    SQ_IDLE = 5'b00001,
    SQ_SQX  = 5'b00010,
    SQ_SQZ  = 5'b00100,
    SQ_RUN  = 5'b01000,
    SQ_DONE = 5'b10000
  } sq_state_t;

  sq_state_t                   state;
  logic [splg_pkg::DIFF_W-1:0] xm;
  logic [splg_pkg::DIFF_W-1:0] zm;
  logic [splg_pkg::DIFF_W-1:0] opnd;
  logic [splg_pkg::SQ_W-1:0]   sq;
  logic [splg_pkg::SQ_W-1:0]   v;
  logic [splg_pkg::SQ_W-1:0]   r;
  logic [splg_pkg::SQ_W-1:0]   rbit;
  logic [splg_pkg::SQ_W-1:0]   rb;
  logic [4:0]                  cnt;

  assign opnd = (state == SQ_SQX) ? xm : zm;
  assign sq   = splg_pkg::SQ_W'(opnd * opnd);
  assign rb   = r + rbit;
  assign done = (state == SQ_DONE);
  assign len  = splg_pkg::LEN_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      case (state)
        SQ_IDLE: begin
          if (start) begin
            xm    <= (dx < 0) ? splg_pkg::DIFF_W'(-dx) : splg_pkg::DIFF_W'(dx);
            zm    <= (dz < 0) ? splg_pkg::DIFF_W'(-dz) : splg_pkg::DIFF_W'(dz);
            state <= SQ_SQX;
          end
        end
        SQ_SQX: begin
          len2  <= sq;
          state <= SQ_SQZ;
        end
        SQ_SQZ: begin
          len2  <= len2 + sq;
          v     <= len2 + sq;
          r     <= '0;
          rbit  <= splg_pkg::SQ_W'(1) << (splg_pkg::SQ_W - 2);
          cnt   <= 5'd20;
          state <= SQ_RUN;
        end
        SQ_RUN: begin
          if (v >= rb) begin
            v <= v - rb;
            r <= (r >> 1) + rbit;
          end else begin
            r <= r >> 1;
          end
          rbit <= rbit >> 2;
          if (cnt == 5'd0) begin
            state <= SQ_DONE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        SQ_DONE: begin
          state <= SQ_IDLE;
        end
        default: begin
          state <= SQ_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/styled_polyline_line_generator.sv */
// ----------------------------------------------------------------------------
// styled_polyline_line_generator
// Turns path waypoints into styled line pieces with an optional arrowhead.
// ----------------------------------------------------------------------------
// Input channel pt_valid/pt_ready carries one waypoint per request; output
// channel line_valid/line_ready carries one line per request. A first point
// latches style, colour and arrow flag, gives no lines and leaves pt_ready
// high. Each later point has its segment measured by the square-root unit;
// patterned pieces and arrowheads then use the shared scaling unit, one
// round(a*b/d) per job: 6 jobs for the segment constants when a pattern or
// arrowhead needs them, 4 per dash, 2 per zigzag step. A backward-style
// dash adds a tick and an arrowhead adds two lines. Pieces go to a line
// buffer of MAX_LINES entries; once the waypoint is complete the buffer is
// drained one line at a time through the DRRD, DRLD and DRWT states while
// the receiver takes them, so a stalled receiver simply holds line_valid
// with the payload steady and stretches the drain. pt_ready is low from
// acceptance until the last line of the waypoint is taken. A solid segment
// without an arrowhead goes from measuring straight to its line; a
// patterned one, unless very short, runs the setup jobs before its first
// piece. Reset empties the buffer and clears the held path state; the block
// is ready in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module styled_polyline_line_generator #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int MAX_LINES       = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pt_valid,
  output logic             pt_ready,
  input  wire logic        first_point,
  input  wire logic        last_point,
  input  wire logic [2:0]  line_style,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic        want_arrow,
  input  wire logic signed [19:0] point_x,
  input  wire logic signed [19:0] point_z,
  output logic             line_valid,
  input  wire logic        line_ready,
  output logic signed [19:0] x_start,
  output logic signed [19:0] z_start,
  output logic signed [19:0] x_end,
  output logic signed [19:0] z_end,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic             last_line,
  output logic             truncated
);

  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int AW = $clog2(MAX_LINES);
  localparam int CR = splg_pkg::COORD_W;
  localparam int SW = splg_pkg::SUM_W;
  localparam int BW = splg_pkg::MULB_W;
  localparam logic [BW-1:0] ONE     = BW'(1 << COORD_FRAC_BITS);
  localparam logic [BW-1:0] HALF    = BW'(1 << (COORD_FRAC_BITS - 1));
  localparam logic [BW-1:0] THALF   = BW'(3 << (COORD_FRAC_BITS - 1));
  localparam logic [BW-1:0] TWO_ONE = BW'(2 << COORD_FRAC_BITS);
  localparam logic [BW-1:0] TONE    = BW'(3 << COORD_FRAC_BITS);
  localparam logic [splg_pkg::SQ_W-1:0] SHORT_LIM =
    splg_pkg::SQ_W'(((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999999) / 64'd1000000);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'b00000000000000001,
    ST_SQRT   = 17'b00000000000000010,
    ST_SETUP  = 17'b00000000000000100,
    ST_BODY   = 17'b00000000000001000,
    ST_SOLID  = 17'b00000000000010000,
    ST_PAT    = 17'b00000000000100000,
    ST_PATDIV = 17'b00000000001000000,
    ST_PATWR  = 17'b00000000010000000,
    ST_PATTK  = 17'b00000000100000000,
    ST_ZIG    = 17'b00000001000000000,
    ST_ZIGDIV = 17'b00000010000000000,
    ST_ZIGWR  = 17'b00000100000000000,
    ST_ARR1   = 17'b00001000000000000,
    ST_ARR2   = 17'b00010000000000000,
    ST_DRRD   = 17'b00100000000000000,
    ST_DRLD   = 17'b01000000000000000,
    ST_DRWT   = 17'b10000000000000000
  } gen_state_t;

  gen_state_t state;

  logic [2:0]  held_style;
  logic [7:0]  held_red;
  logic [7:0]  held_green;
  logic [7:0]  held_blue;
  logic        held_arrow;
  logic [1:0]  points_seen;
  logic signed [CR-1:0] prev_x;
  logic signed [CR-1:0] prev_z;
  logic signed [CR-1:0] org_x;
  logic signed [CR-1:0] org_z;
  logic signed [CR-1:0] cur_x;
  logic signed [CR-1:0] cur_z;
  logic signed [splg_pkg::DIFF_W-1:0] dx;
  logic signed [splg_pkg::DIFF_W-1:0] dz;
  logic        cur_last;
  logic [splg_pkg::LEN_W-1:0] len;
  logic        short_seg;
  logic [splg_pkg::LEN_W-1:0] steps;
  logic [BW-1:0] t;
  logic [BW-1:0] e;
  logic        draw;
  logic [BW-1:0] k;
  logic signed [SW-1:0] px;
  logic signed [SW-1:0] pz;
  logic signed [splg_pkg::QS_W-1:0] cst [6];
  logic signed [splg_pkg::QS_W-1:0] lq [4];
  logic [2:0]  op;
  logic        dpend;
  logic [CW-1:0] nlines;
  logic        cut;
  logic [CW-1:0] rd_idx;
  logic        sq_start;

  logic signed [splg_pkg::DIFF_W-1:0] dx_new;
  logic signed [splg_pkg::DIFF_W-1:0] dz_new;
  logic        sq_done;
  logic [splg_pkg::LEN_W-1:0] sq_len;
  logic [splg_pkg::SQ_W-1:0]  sq_len2;
  logic        short_now;
  logic        style_pat;
  logic        need_setup;
  logic        arrow_go;
  splg_pkg::div_req_t div_req;
  logic        div_done;
  logic signed [splg_pkg::QS_W-1:0] div_q;
  logic        job_st;
  logic [2:0]  op_last;
  logic [BW-1:0] on_len;
  logic [BW-1:0] off_len;
  logic [BW-1:0] t_on;
  logic [BW-1:0] t_off;
  logic [BW-1:0] len_ext;
  logic [splg_pkg::LEN_W-1:0] steps_raw;
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sz;
  logic signed [SW-1:0] cx;
  logic signed [SW-1:0] cz;
  logic signed [SW-1:0] tx;
  logic signed [SW-1:0] tz;
  logic signed [SW-1:0] zh;
  logic signed [SW-1:0] xh;
  logic signed [SW-1:0] ws_x;
  logic signed [SW-1:0] ws_z;
  logic signed [SW-1:0] we_x;
  logic signed [SW-1:0] we_z;
  logic        emit_st;
  logic        full;
  logic        ram_we;
  logic [splg_pkg::LINE_W-1:0] ram_wdata;
  logic [splg_pkg::LINE_W-1:0] ram_rdata;

  assign pt_ready   = (state == ST_IDLE);
  assign line_valid = (state == ST_DRWT);
  assign red_out    = held_red;
  assign green_out  = held_green;
  assign blue_out   = held_blue;

  assign dx_new    = splg_pkg::DIFF_W'(point_x) - splg_pkg::DIFF_W'(prev_x);
  assign dz_new    = splg_pkg::DIFF_W'(point_z) - splg_pkg::DIFF_W'(prev_z);
  assign short_now = (sq_len2 < SHORT_LIM);
  assign style_pat = (held_style == splg_pkg::STYLE_DASHED) ||
                     (held_style == splg_pkg::STYLE_ZIGZAG) ||
                     (held_style == splg_pkg::STYLE_DOTTED) ||
                     (held_style == splg_pkg::STYLE_BACKWARD);
  assign need_setup = !short_now && (style_pat || (cur_last && held_arrow));
  assign arrow_go   = cur_last && held_arrow && !short_seg;
  assign full       = (nlines == CW'(MAX_LINES));
  assign len_ext    = BW'(len);
  assign steps_raw  = len >> (COORD_FRAC_BITS + 1);

  always_comb begin
    case (held_style)
      splg_pkg::STYLE_DASHED: begin
        on_len  = TWO_ONE;
        off_len = THALF;
      end
      splg_pkg::STYLE_DOTTED: begin
        on_len  = HALF;
        off_len = THALF;
      end
      default: begin
        on_len  = TONE;
        off_len = ONE;
      end
    endcase
  end

  assign t_on  = ((t + on_len) > len_ext) ? len_ext : (t + on_len);
  assign t_off = ((t + off_len) > len_ext) ? len_ext : (t + off_len);

  // scaling jobs
  assign job_st = (state == ST_SETUP) || (state == ST_PATDIV) || (state == ST_ZIGDIV);

  always_comb begin
    div_req.start = job_st && !dpend;
    div_req.a     = op[0] ? dz : dx;
    div_req.b     = e;
    div_req.d     = len;
    op_last       = 3'd1;
    case (state)
      ST_SETUP: begin
        div_req.a = (op == 3'd1 || op == 3'd3 || op == 3'd4) ? dx : dz;
        div_req.b = (op < 3'd2) ? THALF : ((op < 3'd4) ? ONE : TONE);
        op_last   = 3'd5;
      end
      ST_PATDIV: begin
        div_req.b = op[1] ? e : t;
        op_last   = 3'd3;
      end
      ST_ZIGDIV: begin
        div_req.b = k;
        div_req.d = steps;
      end
      default: begin
        op_last = 3'd1;
      end
    endcase
  end

  // line end points
  assign zh = SW'(cst[0]);
  assign xh = SW'(cst[1]);
  assign sx = SW'(org_x) + SW'(lq[0]);
  assign sz = SW'(org_z) + SW'(lq[1]);
  assign tx = SW'(cur_x) + SW'(cst[4]);
  assign tz = SW'(cur_z) + SW'(cst[5]);

  always_comb begin
    cx = sx;
    cz = sz;
    if (k != BW'(steps)) begin
      if (k[0]) begin
        cx = sx - zh;
        cz = sz + xh;
      end else begin
        cx = sx + zh;
        cz = sz - xh;
      end
    end
  end

  always_comb begin
    emit_st = 1'b1;
    ws_x    = SW'(org_x);
    ws_z    = SW'(org_z);
    we_x    = SW'(cur_x);
    we_z    = SW'(cur_z);
    case (state)
      ST_SOLID: begin
        emit_st = 1'b1;
      end
      ST_PATWR: begin
        ws_x = sx;
        ws_z = sz;
        we_x = SW'(org_x) + SW'(lq[2]);
        we_z = SW'(org_z) + SW'(lq[3]);
      end
      ST_PATTK: begin
        ws_x = sx + SW'(cst[2]);
        ws_z = sz - SW'(cst[3]);
        we_x = sx - SW'(cst[2]);
        we_z = sz + SW'(cst[3]);
      end
      ST_ZIGWR: begin
        ws_x = px;
        ws_z = pz;
        we_x = cx;
        we_z = cz;
      end
      ST_ARR1: begin
        ws_x = tx;
        ws_z = tz;
        we_x = SW'(cur_x) - zh;
        we_z = SW'(cur_z) + xh;
      end
      ST_ARR2: begin
        ws_x = tx;
        ws_z = tz;
        we_x = SW'(cur_x) + zh;
        we_z = SW'(cur_z) - xh;
      end
      default: begin
        emit_st = 1'b0;
      end
    endcase
  end

  assign ram_we    = emit_st && !full;
  assign ram_wdata = {splg_pkg::sat_coord(ws_x), splg_pkg::sat_coord(ws_z),
                      splg_pkg::sat_coord(we_x), splg_pkg::sat_coord(we_z)};

  splg_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .dx   (dx),
    .dz   (dz),
    .done (sq_done),
    .len  (sq_len),
    .len2 (sq_len2)
  );

  splg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .done(div_done),
    .quo (div_q)
  );

  splg_ram #(
    .WIDTH(splg_pkg::LINE_W),
    .DEPTH(MAX_LINES)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(nlines[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      held_style  <= splg_pkg::STYLE_SOLID;
      held_red    <= '0;
      held_green  <= '0;
      held_blue   <= '0;
      held_arrow  <= 1'b0;
      points_seen <= splg_pkg::PTS_NONE;
      prev_x      <= '0;
      prev_z      <= '0;
      nlines      <= '0;
      cut         <= 1'b0;
      rd_idx      <= '0;
      dpend       <= 1'b0;
      op          <= '0;
      sq_start    <= 1'b0;
    end else begin
      if (job_st) begin
        if (!dpend) begin
          dpend <= 1'b1;
        end
        if (div_done) begin
          dpend <= 1'b0;
          if (state == ST_SETUP) begin
            cst[op] <= div_q;
          end else begin
            lq[op[1:0]] <= div_q;
          end
          op <= (op == op_last) ? 3'd0 : op + 3'd1;
        end
      end
      if (emit_st) begin
        if (full) begin
          cut <= 1'b1;
        end else begin
          nlines <= nlines + 1'b1;
        end
      end
      case (state)
        ST_IDLE: begin
          if (pt_valid) begin
            nlines <= '0;
            cut    <= 1'b0;
            rd_idx <= '0;
            op     <= '0;
            dpend  <= 1'b0;
            if (first_point) begin
              held_style <= line_style;
              held_red   <= red_in;
              held_green <= green_in;
              held_blue  <= blue_in;
              held_arrow <= want_arrow;
            end
            prev_x <= point_x;
            prev_z <= point_z;
            if (first_point || points_seen == splg_pkg::PTS_NONE) begin
              points_seen <= last_point ? splg_pkg::PTS_NONE : splg_pkg::PTS_ONE;
            end else begin
              points_seen <= last_point ? splg_pkg::PTS_NONE : splg_pkg::PTS_MORE;
              org_x    <= prev_x;
              org_z    <= prev_z;
              cur_x    <= point_x;
              cur_z    <= point_z;
              dx       <= dx_new;
              dz       <= dz_new;
              cur_last <= last_point;
              sq_start <= 1'b1;
              state    <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          sq_start <= 1'b0;
          if (sq_done) begin
            len       <= sq_len;
            short_seg <= short_now;
            state     <= need_setup ? ST_SETUP : ST_BODY;
          end
        end
        ST_SETUP: begin
          if (div_done && op == op_last) begin
            state <= ST_BODY;
          end
        end
        ST_BODY: begin
          if (!style_pat) begin
            state <= ST_SOLID;
          end else if (short_seg) begin
            state <= ST_DRRD;
          end else if (held_style == splg_pkg::STYLE_ZIGZAG) begin
            steps <= (steps_raw == '0) ? splg_pkg::LEN_W'(1) : steps_raw;
            k     <= BW'(1);
            px    <= SW'(org_x);
            pz    <= SW'(org_z);
            state <= ST_ZIG;
          end else begin
            t     <= '0;
            draw  <= 1'b1;
            state <= ST_PAT;
          end
        end
        ST_SOLID: begin
          state <= arrow_go ? ST_ARR1 : ST_DRRD;
        end
        ST_PAT: begin
          if (t >= len_ext) begin
            state <= arrow_go ? ST_ARR1 : ST_DRRD;
          end else if (draw) begin
            if (full) begin
              cut   <= 1'b1;
              state <= ST_DRRD;
            end else begin
              e     <= t_on;
              state <= ST_PATDIV;
            end
          end else begin
            t    <= t_off;
            draw <= 1'b1;
          end
        end
        ST_PATDIV: begin
          if (div_done && op == op_last) begin
            state <= ST_PATWR;
          end
        end
        ST_PATWR: begin
          t    <= e;
          draw <= 1'b0;
          state <= (held_style == splg_pkg::STYLE_BACKWARD) ? ST_PATTK : ST_PAT;
        end
        ST_PATTK: begin
          state <= full ? ST_DRRD : ST_PAT;
        end
        ST_ZIG: begin
          if (k > BW'(steps)) begin
            state <= arrow_go ? ST_ARR1 : ST_DRRD;
          end else if (full) begin
            cut   <= 1'b1;
            state <= ST_DRRD;
          end else begin
            state <= ST_ZIGDIV;
          end
        end
        ST_ZIGDIV: begin
          if (div_done && op == op_last) begin
            state <= ST_ZIGWR;
          end
        end
        ST_ZIGWR: begin
          px    <= cx;
          pz    <= cz;
          k     <= k + 1'b1;
          state <= ST_ZIG;
        end
        ST_ARR1: begin
          state <= full ? ST_DRRD : ST_ARR2;
        end
        ST_ARR2: begin
          state <= ST_DRRD;
        end
        ST_DRRD: begin
          state <= (nlines == '0) ? ST_IDLE : ST_DRLD;
        end
        ST_DRLD: begin
          x_start   <= $signed(ram_rdata[4*CR-1:3*CR]);
          z_start   <= $signed(ram_rdata[3*CR-1:2*CR]);
          x_end     <= $signed(ram_rdata[2*CR-1:CR]);
          z_end     <= $signed(ram_rdata[CR-1:0]);
          last_line <= (rd_idx == nlines - 1'b1);
          truncated <= cut;
          state     <= ST_DRWT;
        end
        ST_DRWT: begin
          if (line_ready) begin
            if (last_line) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= ST_DRRD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
